// File: rtl/afsm_pkg.sv
package afsm_pkg;

	localparam int SMP_W      = 8;
	localparam int GAIN_W     = 10;
	localparam int PROD_W     = SMP_W + GAIN_W + 1;
	localparam int SUM_W      = PROD_W + 2;
	localparam int VOL_W      = 3;
	localparam int VSUM_W     = SUM_W + VOL_W + 1;
	localparam int SCL_W      = VSUM_W - 3;
	localparam int FIN_W      = SCL_W + GAIN_W + 1;
	localparam int NUM_CH     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CD_W       = 16;
	localparam int STEP_W     = 3;
	localparam int WAVE_DEPTH = 16;
	localparam int WAVE_IDX_W = $clog2(WAVE_DEPTH);

	typedef logic signed [SMP_W-1:0]  smp_t;
	typedef logic        [GAIN_W-1:0] gain_t;
	typedef logic signed [PROD_W-1:0] term_t;
	typedef logic signed [SCL_W-1:0]  scl_t;

	typedef enum logic [1:0] {
		OP_ADVANCE = 2'd0,
		OP_WRITE   = 2'd1,
		OP_READ    = 2'd2,
		OP_IDLE    = 2'd3
	} op_e;

	localparam logic [CFG_IDX_W-1:0] CFG_MASTER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CH1    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CH2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CH3    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CH4    = 3'd4;

	localparam gain_t GAIN_RESET = 10'd256;

	localparam logic [15:0] BUS_BASE    = 16'hFF00;
	localparam logic [15:0] OFF_NR50    = 16'h0024;
	localparam logic [15:0] OFF_NR51    = 16'h0025;
	localparam logic [15:0] OFF_NR52    = 16'h0026;
	localparam logic [15:0] OFF_WAVE_LO = 16'h0030;
	localparam logic [15:0] OFF_WAVE_HI = 16'h003F;

	localparam logic [7:0] STATUS_FILL = 8'h70;
	localparam logic [7:0] UNMAPPED    = 8'hFF;
	localparam logic [7:0] SILENCE     = 8'h80;

	typedef struct packed {
		logic [NUM_CH-1:0] route_l;
		logic [NUM_CH-1:0] route_r;
		logic [VOL_W-1:0]  vol_l;
		logic [VOL_W-1:0]  vol_r;
	} mix_sel_t;

	typedef struct packed {
		logic len;
		logic swp;
		logic env;
		logic smp;
	} tick_t;

endpackage

// File: rtl/afsm_lane.sv
module afsm_lane #(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic           clk,
	input  logic           en,
	input  afsm_pkg::smp_t  smp,
	input  afsm_pkg::gain_t gain,
	output afsm_pkg::term_t term_s1
);
	import afsm_pkg::*;

	localparam term_t BIAS = term_t'((1 << GAIN_FRAC_BITS) - 1);

	term_t prod;
	term_t bias;
	term_t trunc;

	// Product is truncated toward zero: negative values get a rounding bias first.
	assign prod  = term_t'(smp) * $signed({1'b0, gain});
	assign bias  = prod[PROD_W-1] ? BIAS : term_t'(0);
	assign trunc = (prod + bias) >>> GAIN_FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			term_s1 <= trunc;
		end
	end

endmodule

// File: rtl/afsm_merge.sv
module afsm_merge #(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               en_s2,
	input  logic               en_s3,
	input  afsm_pkg::term_t     term_s1 [afsm_pkg::NUM_CH],
	input  afsm_pkg::mix_sel_t  sel_s1,
	input  afsm_pkg::gain_t     master,
	output logic [7:0]         left_s3,
	output logic [7:0]         right_s3
);
	import afsm_pkg::*;

	localparam logic signed [FIN_W-1:0] BIAS     = FIN_W'((1 << GAIN_FRAC_BITS) - 1);
	localparam logic signed [FIN_W-1:0] CLAMP_LO = -FIN_W'(128);
	localparam logic signed [FIN_W-1:0] CLAMP_HI = FIN_W'(127);

	logic [NUM_CH-1:0]          route [2];
	logic [VOL_W-1:0]           vol   [2];
	logic signed [SUM_W-1:0]    sum   [2];
	logic signed [VSUM_W-1:0]   vsum  [2];
	scl_t                       scl   [2];
	scl_t                       scl_s2 [2];
	logic signed [FIN_W-1:0]    fin   [2];
	logic signed [FIN_W-1:0]    trn   [2];
	logic [7:0]                 clp   [2];
	logic [7:0]                 byte_o [2];

	// Side 0 is left, side 1 is right.
	always_comb begin
		route[0] = sel_s1.route_l;
		route[1] = sel_s1.route_r;
		vol[0]   = sel_s1.vol_l;
		vol[1]   = sel_s1.vol_r;
		for (int s = 0; s < 2; s++) begin
			sum[s] = SUM_W'(0);
			for (int c = 0; c < NUM_CH; c++) begin
				if (route[s][c]) begin
					sum[s] = sum[s] + SUM_W'(term_s1[c]);
				end
			end
			vsum[s] = VSUM_W'(sum[s]) * $signed({1'b0, vol[s]});
			scl[s]  = SCL_W'(vsum[s] >>> 3);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			scl_s2[0] <= scl[0];
			scl_s2[1] <= scl[1];
		end
	end

	// Master gain, truncation toward zero, clamp to a signed byte and offset by 128.
	always_comb begin
		for (int s = 0; s < 2; s++) begin
			fin[s] = FIN_W'(scl_s2[s]) * $signed({1'b0, master});
			trn[s] = (fin[s] + (fin[s][FIN_W-1] ? BIAS : FIN_W'(0))) >>> GAIN_FRAC_BITS;
			if (trn[s] < CLAMP_LO) begin
				clp[s] = 8'h80;
			end else if (trn[s] > CLAMP_HI) begin
				clp[s] = 8'h7F;
			end else begin
				clp[s] = trn[s][7:0];
			end
			byte_o[s] = {~clp[s][7], clp[s][6:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			left_s3  <= byte_o[0];
			right_s3 <= byte_o[1];
		end
	end

endmodule

// File: rtl/afsm_timer.sv
module afsm_timer #(
	parameter int FRAME_PERIOD  = 8192,
	parameter int SAMPLE_PERIOD = 95
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            clr,
	input  logic [7:0]      cycles,
	output afsm_pkg::tick_t tick
);
	import afsm_pkg::*;

	localparam logic [STEP_W-1:0] SWEEP_STEP_A = 3'd2;
	localparam logic [STEP_W-1:0] SWEEP_STEP_B = 3'd6;
	localparam logic [STEP_W-1:0] ENV_STEP     = 3'd7;
	localparam logic signed [CD_W:0] F_PER = (CD_W+1)'(FRAME_PERIOD);
	localparam logic signed [CD_W:0] S_PER = (CD_W+1)'(SAMPLE_PERIOD);
	localparam logic signed [CD_W:0] SAT   = -(CD_W+1)'(32768);

	logic signed [CD_W-1:0] fcd_q;
	logic signed [CD_W-1:0] scd_q;
	logic [STEP_W-1:0]      step_q;
	logic [CD_W:0]          fnext;
	logic [CD_W:0]          snext;

	// Returns the fire flag above the new countdown value.
	function automatic logic [CD_W:0] count_down(
		input logic signed [CD_W-1:0] cd,
		input logic [7:0]             cyc,
		input logic signed [CD_W:0]   period
	);
		logic signed [CD_W:0] t;
		logic                 fire;
		t = (CD_W+1)'(cd) - $signed({1'b0, (CD_W)'(cyc)});
		if (t < SAT) begin
			t = SAT;
		end
		fire = (t <= (CD_W+1)'(0));
		if (fire) begin
			t = t + period;
		end
		return {fire, t[CD_W-1:0]};
	endfunction

	assign fnext = count_down(fcd_q, cycles, F_PER);
	assign snext = count_down(scd_q, cycles, S_PER);

	always_comb begin
		tick.len = adv && fnext[CD_W] && !step_q[0];
		tick.swp = adv && fnext[CD_W] && (step_q == SWEEP_STEP_A || step_q == SWEEP_STEP_B);
		tick.env = adv && fnext[CD_W] && (step_q == ENV_STEP);
		tick.smp = adv && snext[CD_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcd_q  <= '0;
			scd_q  <= '0;
			step_q <= '0;
		end else if (clr) begin
			fcd_q  <= '0;
			scd_q  <= '0;
			step_q <= '0;
		end else if (adv) begin
			fcd_q <= fnext[CD_W-1:0];
			scd_q <= snext[CD_W-1:0];
			if (fnext[CD_W]) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

endmodule

// File: rtl/afsm_regfile.sv
module afsm_regfile (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           acc,
	input  afsm_pkg::op_e  op,
	input  logic [15:0]    address,
	input  logic [7:0]     write_data,
	input  logic [3:0]     channel_active,
	output logic           sound_on,
	output logic [7:0]     mix_ctrl,
	output logic [7:0]     pan_ctrl,
	output logic           clr,
	output logic [7:0]     rdata_s1
);
	import afsm_pkg::*;

	logic [15:0]           off;
	logic                  wr;
	logic                  allowed;
	logic                  wave_hit;
	logic                  wave_we;
	logic [WAVE_IDX_W-1:0] widx;
	logic [7:0]            reg_byte;
	logic                  sound_on_q;
	logic [7:0]            mix_q;
	logic [7:0]            pan_q;
	logic [WAVE_DEPTH-1:0] wave_vld_q;
	logic [7:0]            wave_mem [WAVE_DEPTH];
	logic                  rd_s1;
	logic                  whit_s1;
	logic                  wok_s1;
	logic [7:0]            wave_s1;
	logic [7:0]            rreg_s1;

	assign off      = address - BUS_BASE;
	assign wr       = acc && (op == OP_WRITE);
	assign allowed  = sound_on_q || (off >= OFF_NR52);
	assign wave_hit = (off >= OFF_WAVE_LO) && (off <= OFF_WAVE_HI);
	assign widx     = off[WAVE_IDX_W-1:0];
	assign wave_we  = wr && allowed && wave_hit;
	assign clr      = wr && (off == OFF_NR52) && sound_on_q && !write_data[7];

	assign sound_on = sound_on_q;
	assign mix_ctrl = mix_q;
	assign pan_ctrl = pan_q;

	// Powering off clears the registers; wave entries read as zero until rewritten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sound_on_q <= 1'b0;
			mix_q      <= '0;
			pan_q      <= '0;
			wave_vld_q <= '0;
		end else if (clr) begin
			sound_on_q <= 1'b0;
			mix_q      <= '0;
			pan_q      <= '0;
			wave_vld_q <= '0;
		end else if (wr && allowed) begin
			unique case (off)
				OFF_NR50: mix_q      <= write_data;
				OFF_NR51: pan_q      <= write_data;
				OFF_NR52: sound_on_q <= write_data[7];
				default: begin
					if (wave_hit) begin
						wave_vld_q[widx] <= 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wave_we) begin
			wave_mem[widx] <= write_data;
		end
	end

	always_comb begin
		unique case (off)
			OFF_NR50: reg_byte = mix_q;
			OFF_NR51: reg_byte = pan_q;
			OFF_NR52: reg_byte = STATUS_FILL | {sound_on_q, 3'b000, channel_active};
			default:  reg_byte = UNMAPPED;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1   <= (op == OP_READ);
			whit_s1 <= wave_hit;
			wok_s1  <= wave_vld_q[widx];
			wave_s1 <= wave_mem[widx];
			rreg_s1 <= reg_byte;
		end
	end

	always_comb begin
		if (!rd_s1) begin
			rdata_s1 = '0;
		end else if (whit_s1) begin
			rdata_s1 = wok_s1 ? wave_s1 : 8'h00;
		end else begin
			rdata_s1 = rreg_s1;
		end
	end

endmodule

// File: rtl/apu_frame_sequencer_mixer.sv
// Channel  | Direction | Handshake         | Payload
// cfg      | in        | cfg_wen           | cfg_index, cfg_data
// in       | in        | in_valid/in_stall | operation .. channel_active
// out      | out       | out_valid/out_stall | ticks, samples, read_data
//
// Every item passes registered stages on its way to the output register: the four channel
// multiplier lanes, then the side sums and volume scaling, then the master gain stage.
// No new input transfer is taken while an item is in any of these stages.
// The next item is taken once the previous one has left the pipeline, even while its
// result still waits in the output register.
// arst_n clears all sound state, the pipeline and output valids, and sets the gains to 1.0.
module apu_frame_sequencer_mixer #(
	parameter int FRAME_PERIOD   = 8192,
	parameter int SAMPLE_PERIOD  = 95,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [afsm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  afsm_pkg::gain_t                  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       operation,
	input  logic [7:0]                       cycles,
	input  logic [15:0]                      address,
	input  logic [7:0]                       write_data,
	input  afsm_pkg::smp_t                   sample_ch1,
	input  afsm_pkg::smp_t                   sample_ch2,
	input  afsm_pkg::smp_t                   sample_ch3,
	input  afsm_pkg::smp_t                   sample_ch4,
	input  logic [3:0]                       channel_active,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             length_tick,
	output logic                             sweep_tick,
	output logic                             envelope_tick,
	output logic                             sample_valid,
	output logic [7:0]                       left_sample,
	output logic [7:0]                       right_sample,
	output logic [7:0]                       read_data
);
	import afsm_pkg::*;

	op_e      op;
	logic     acc;
	logic     adv;
	logic     clr;
	logic     sound_on;
	logic [7:0] mix_ctrl;
	logic [7:0] pan_ctrl;
	tick_t    tick;
	gain_t    master_gain_q;
	gain_t    ch_gain_q [NUM_CH];
	smp_t     smp_in [NUM_CH];
	term_t    term_s1 [NUM_CH];
	mix_sel_t sel_s1;
	tick_t    tick_s1;
	tick_t    tick_s2;
	tick_t    tick_s3;
	logic [7:0] rdata_s1;
	logic [7:0] rdata_s2;
	logic [7:0] rdata_s3;
	logic [7:0] left_s3;
	logic [7:0] right_s3;
	logic     v_s1;
	logic     v_s2;
	logic     v_s3;
	logic     out_load;
	logic     out_valid_q;
	tick_t    tick_q;
	logic [7:0] left_q;
	logic [7:0] right_q;
	logic [7:0] rdata_q;

	assign op       = op_e'(operation);
	assign in_stall = v_s1 || v_s2 || v_s3;
	assign acc      = in_valid && !in_stall;
	assign adv      = acc && (op == OP_ADVANCE);
	assign out_load = v_s3 && (!out_valid_q || !out_stall);

	assign smp_in[0] = sample_ch1;
	assign smp_in[1] = sample_ch2;
	assign smp_in[2] = sample_ch3;
	assign smp_in[3] = sample_ch4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_gain_q <= GAIN_RESET;
			for (int c = 0; c < NUM_CH; c++) begin
				ch_gain_q[c] <= GAIN_RESET;
			end
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_MASTER: master_gain_q <= cfg_data;
				CFG_CH1:    ch_gain_q[0]  <= cfg_data;
				CFG_CH2:    ch_gain_q[1]  <= cfg_data;
				CFG_CH3:    ch_gain_q[2]  <= cfg_data;
				CFG_CH4:    ch_gain_q[3]  <= cfg_data;
				default: ;
			endcase
		end
	end

	afsm_timer #(
		.FRAME_PERIOD  (FRAME_PERIOD),
		.SAMPLE_PERIOD (SAMPLE_PERIOD)
	) u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.clr    (clr),
		.cycles (cycles),
		.tick   (tick)
	);

	afsm_regfile u_regfile (
		.clk            (clk),
		.arst_n         (arst_n),
		.acc            (acc),
		.op             (op),
		.address        (address),
		.write_data     (write_data),
		.channel_active (channel_active),
		.sound_on       (sound_on),
		.mix_ctrl       (mix_ctrl),
		.pan_ctrl       (pan_ctrl),
		.clr            (clr),
		.rdata_s1       (rdata_s1)
	);

	for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
		afsm_lane #(
			.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
		) u_lane (
			.clk     (clk),
			.en      (acc),
			.smp     (smp_in[c]),
			.gain    (ch_gain_q[c]),
			.term_s1 (term_s1[c])
		);
	end

	afsm_merge #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_merge (
		.clk      (clk),
		.en_s2    (v_s1),
		.en_s3    (v_s2),
		.term_s1  (term_s1),
		.sel_s1   (sel_s1),
		.master   (master_gain_q),
		.left_s3  (left_s3),
		.right_s3 (right_s3)
	);

	always_ff @(posedge clk) begin
		if (acc) begin
			tick_s1     <= '{len: tick.len, swp: tick.swp, env: tick.env,
			                 smp: tick.smp && sound_on};
			sel_s1      <= '{route_l: pan_ctrl[7:4], route_r: pan_ctrl[3:0],
			                 vol_l: mix_ctrl[6:4], vol_r: mix_ctrl[2:0]};
		end
		if (v_s1) begin
			tick_s2  <= tick_s1;
			rdata_s2 <= rdata_s1;
		end
		if (v_s2) begin
			tick_s3  <= tick_s2;
			rdata_s3 <= rdata_s2;
		end
		if (out_load) begin
			tick_q  <= tick_s3;
			left_q  <= tick_s3.smp ? left_s3 : SILENCE;
			right_q <= tick_s3.smp ? right_s3 : SILENCE;
			rdata_q <= rdata_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1        <= acc;
			v_s2        <= v_s1;
			v_s3        <= v_s2 || (v_s3 && !out_load);
			out_valid_q <= out_load || (out_valid_q && out_stall);
		end
	end

	assign out_valid     = out_valid_q;
	assign length_tick   = tick_q.len;
	assign sweep_tick    = tick_q.swp;
	assign envelope_tick = tick_q.env;
	assign sample_valid  = tick_q.smp;
	assign left_sample   = left_q;
	assign right_sample  = right_q;
	assign read_data     = rdata_q;

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1, v_s2, v_s3}))
		else $error("more than one item in the mixing pipeline");

	a_silence: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sample_valid |-> left_sample == SILENCE && right_sample == SILENCE)
		else $error("samples not silent without a mixed sample");

	a_tick_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(sweep_tick && envelope_tick))
		else $error("sweep and envelope pulses on the same step");

	a_sweep_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sweep_tick |-> length_tick)
		else $error("sweep pulse on a step without a length pulse");
`endif

endmodule

// File: tb/tb_top.sv
module tb_top;
	import afsm_pkg::*;

	localparam int FRAME_LEN   = 8192;
	localparam int SAMPLE_LEN  = 95;
	localparam int GAIN_SHIFT  = 8;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASES      = 6;

	localparam logic [CFG_IDX_W-1:0] GAIN_REGS [5] = '{CFG_MASTER, CFG_CH1, CFG_CH2, CFG_CH3,
		CFG_CH4};

	typedef struct packed {
		logic       len;
		logic       swp;
		logic       env;
		logic       valid;
		logic [7:0] left;
		logic [7:0] right;
		logic [7:0] rdata;
	} apu_res_t;

	typedef struct {
		op_e         op;
		logic [7:0]  cycles;
		logic [15:0] address;
		logic [7:0]  wdata;
		smp_t        smp [NUM_CH];
		logic [3:0]  active;
	} apu_item_t;

	class apu_mix_checker;
		gain_t      gain [5];
		int         sample_cd;
		int         frame_cd;
		logic [2:0] step;
		bit         sound_on;
		logic [7:0] mix_ctl;
		logic [7:0] pan_ctl;
		logic [7:0] wave [WAVE_DEPTH];
		apu_res_t   pending_results [$];
		int         mismatches;

		function new();
			foreach (gain[i]) gain[i] = GAIN_RESET;
			power_down();
			mismatches = 0;
		endfunction

		function void power_down();
			sample_cd = 0;
			frame_cd  = 0;
			step      = '0;
			sound_on  = 1'b0;
			mix_ctl   = '0;
			pan_ctl   = '0;
			foreach (wave[i]) wave[i] = '0;
		endfunction

		// The subtraction saturates, and at most one period is added back per advance.
		function int tick_timer(int cd, logic [7:0] cyc, int period, output bit fired);
			int t;
			t = cd - int'(cyc);
			if (t < -32768) t = -32768;
			fired = (t <= 0);
			if (fired) t += period;
			return t;
		endfunction

		function logic [7:0] pan_mix(apu_item_t it, logic [3:0] route, logic [2:0] vol);
			int acc;
			acc = 0;
			for (int i = 0; i < NUM_CH; i++)
				if (route[i]) acc += (int'(it.smp[i]) * int'(gain[i + 1])) / (1 << GAIN_SHIFT);
			acc = (acc * int'(vol)) >>> 3;
			acc = (acc * int'(gain[CFG_MASTER])) / (1 << GAIN_SHIFT);
			if (acc < -128) acc = -128;
			if (acc > 127) acc = 127;
			return 8'(acc + 128);
		endfunction

		function void note_item(apu_item_t it);
			apu_res_t    want;
			logic [15:0] off;
			logic [3:0]  slot;
			bit          fired;
			want       = '0;
			want.left  = SILENCE;
			want.right = SILENCE;
			off        = it.address - BUS_BASE;
			slot       = off[3:0];
			case (it.op)
				OP_ADVANCE: begin
					frame_cd = tick_timer(frame_cd, it.cycles, FRAME_LEN, fired);
					if (fired) begin
						want.len = ~step[0];
						want.swp = (step == 3'd2) || (step == 3'd6);
						want.env = (step == 3'd7);
						step     = step + 3'd1;
					end
					sample_cd = tick_timer(sample_cd, it.cycles, SAMPLE_LEN, fired);
					if (fired && sound_on) begin
						want.left  = pan_mix(it, pan_ctl[7:4], mix_ctl[6:4]);
						want.right = pan_mix(it, pan_ctl[3:0], mix_ctl[2:0]);
						want.valid = 1'b1;
					end
				end
				OP_WRITE: begin
					if (sound_on || off >= OFF_NR52) begin
						if (off == OFF_NR50) begin
							mix_ctl = it.wdata;
						end else if (off == OFF_NR51) begin
							pan_ctl = it.wdata;
						end else if (off == OFF_NR52) begin
							if (sound_on && !it.wdata[7]) power_down();
							else sound_on = it.wdata[7];
						end else if (off >= OFF_WAVE_LO && off <= OFF_WAVE_HI) begin
							wave[slot] = it.wdata;
						end
					end
				end
				OP_READ: begin
					if (off == OFF_NR50) want.rdata = mix_ctl;
					else if (off == OFF_NR51) want.rdata = pan_ctl;
					else if (off == OFF_NR52)
						want.rdata = {sound_on, 7'h00} | STATUS_FILL | {4'h0, it.active};
					else if (off >= OFF_WAVE_LO && off <= OFF_WAVE_HI) want.rdata = wave[slot];
					else want.rdata = UNMAPPED;
				end
				default: ;
			endcase
			pending_results.push_back(want);
		endfunction

		function void report(string what, logic [7:0] want, logic [7:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
		endfunction

		function void check_result(apu_res_t got);
			apu_res_t want;
			if (pending_results.size() == 0) begin
				report("unexpected transfer", 8'h00, 8'h01);
				return;
			end
			want = pending_results.pop_front();
			if (got.len !== want.len) report("length_tick", want.len, got.len);
			if (got.swp !== want.swp) report("sweep_tick", want.swp, got.swp);
			if (got.env !== want.env) report("envelope_tick", want.env, got.env);
			if (got.valid !== want.valid) report("sample_valid", want.valid, got.valid);
			if (got.left !== want.left) report("left_sample", want.left, got.left);
			if (got.right !== want.right) report("right_sample", want.right, got.right);
			if (got.rdata !== want.rdata) report("read_data", want.rdata, got.rdata);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	gain_t                cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           operation;
	logic [7:0]           cycles;
	logic [15:0]          address;
	logic [7:0]           write_data;
	smp_t                 sample_ch1;
	smp_t                 sample_ch2;
	smp_t                 sample_ch3;
	smp_t                 sample_ch4;
	logic [3:0]           channel_active;
	logic                 out_valid;
	logic                 out_stall;
	logic                 length_tick;
	logic                 sweep_tick;
	logic                 envelope_tick;
	logic                 sample_valid;
	logic [7:0]           left_sample;
	logic [7:0]           right_sample;
	logic [7:0]           read_data;

	apu_mix_checker sb;
	gain_t          next_gain [5];
	int             src_idle_pct   = 0;
	int             sink_stall_pct = 0;
	int             hold_left      = 0;
	int             quiet_cycles   = 0;

	apu_frame_sequencer_mixer dut (.*);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(apu_res_t'({length_tick, sweep_tick, envelope_tick, sample_valid,
				left_sample, right_sample, read_data}));
		if (!arst_n || cfg_wen || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("tb_top: errors");
		$finish;
	end

	function automatic apu_item_t rand_item();
		apu_item_t it;
		it.op      = op_e'($urandom_range(3));
		it.cycles  = 8'($urandom);
		it.address = 16'($urandom);
		it.wdata   = 8'($urandom);
		foreach (it.smp[i]) it.smp[i] = smp_t'($urandom);
		it.active  = 4'($urandom);
		return it;
	endfunction

	function automatic logic [15:0] pick_offset();
		case ($urandom_range(9))
			0, 1: return OFF_NR50;
			2, 3: return OFF_NR51;
			4: return OFF_NR52;
			5: return 16'($urandom_range(16'h10, 16'h3F));
			default: return OFF_WAVE_LO + 16'($urandom_range(15));
		endcase
	endfunction

	task automatic send_item(input apu_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		operation      <= it.op;
		cycles         <= it.cycles;
		address        <= it.address;
		write_data     <= it.wdata;
		sample_ch1     <= it.smp[0];
		sample_ch2     <= it.smp[1];
		sample_ch3     <= it.smp[2];
		sample_ch4     <= it.smp[3];
		channel_active <= it.active;
		do @(posedge clk); while (in_stall);
		sb.note_item(it);
	endtask

	task automatic send_fields(input op_e op, input logic [7:0] cyc, input logic [15:0] addr,
		input logic [7:0] wdata);
		apu_item_t it;
		it         = rand_item();
		it.op      = op;
		it.cycles  = cyc;
		it.address = addr;
		it.wdata   = wdata;
		send_item(it);
	endtask

	task automatic send_full_scale(input smp_t level);
		apu_item_t it;
		it        = rand_item();
		it.op     = OP_ADVANCE;
		it.cycles = 8'd255;
		foreach (it.smp[i]) it.smp[i] = level;
		send_item(it);
	endtask

	// Long steps keep every advance near the top of the range so that the sample
	// countdown runs down to its saturation floor.
	task automatic run_random(input int n, input int adv_pct, input bit long_steps);
		apu_item_t it;
		int        roll;
		repeat (n) begin
			it   = rand_item();
			roll = $urandom_range(99);
			if (roll < adv_pct) begin
				it.op = OP_ADVANCE;
				if (long_steps) it.cycles = 8'(255 - $urandom_range(7));
				else if ($urandom_range(1)) it.cycles = 8'($urandom_range(63));
			end else if (roll < adv_pct + (100 - adv_pct) * 9 / 20) begin
				it.op      = OP_WRITE;
				it.address = BUS_BASE + pick_offset();
				if (16'(it.address - BUS_BASE) == OFF_NR52)
					it.wdata[7] = long_steps || ($urandom_range(7) != 0);
			end else if (roll < 96) begin
				it.op      = OP_READ;
				it.address = BUS_BASE + pick_offset();
			end
			send_item(it);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_gains();
		for (int i = 0; i < 5; i++) begin
			@(negedge clk);
			cfg_wen   <= 1'b1;
			cfg_index <= GAIN_REGS[i];
			cfg_data  <= next_gain[i];
			@(posedge clk);
			sb.gain[GAIN_REGS[i]] = next_gain[i];
		end
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	initial begin
		int ph;
		sb             = new();
		arst_n         = 1'b0;
		cfg_wen        = 1'b0;
		cfg_index      = CFG_MASTER;
		cfg_data       = GAIN_RESET;
		in_valid       = 1'b0;
		operation      = OP_IDLE;
		cycles         = '0;
		address        = '0;
		write_data     = '0;
		sample_ch1     = '0;
		sample_ch2     = '0;
		sample_ch3     = '0;
		sample_ch4     = '0;
		channel_active = '0;
		out_stall      = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// While the sound is off, only the power register and the wave RAM take writes.
		send_fields(OP_READ, 8'd0, BUS_BASE | OFF_NR52, 8'h00);
		send_fields(OP_WRITE, 8'd0, BUS_BASE | OFF_NR50, 8'h77);
		send_fields(OP_WRITE, 8'd0, BUS_BASE | OFF_WAVE_LO, 8'h11);
		send_fields(OP_READ, 8'd0, BUS_BASE | OFF_NR50, 8'h00);
		send_fields(OP_ADVANCE, 8'd0, 16'h0000, 8'h00);
		send_fields(OP_WRITE, 8'd0, BUS_BASE | OFF_NR52, 8'h80);
		send_fields(OP_WRITE, 8'd0, BUS_BASE | OFF_NR50, 8'h77);
		send_fields(OP_WRITE, 8'd0, BUS_BASE | OFF_NR51, 8'hFF);
		send_full_scale(smp_t'(127));
		send_full_scale(smp_t'(-128));
		send_fields(OP_WRITE, 8'd0, BUS_BASE | OFF_WAVE_HI, 8'hA5);
		send_fields(OP_READ, 8'd0, BUS_BASE | OFF_WAVE_LO, 8'h00);
		send_fields(OP_READ, 8'd0, BUS_BASE | OFF_WAVE_HI, 8'h00);
		send_fields(OP_READ, 8'd0, 16'hFF10, 8'h00);
		send_fields(OP_READ, 8'd0, OFF_NR52, 8'h00);
		send_fields(OP_WRITE, 8'd0, 16'hFF40, 8'h5A);
		send_fields(OP_IDLE, 8'hFF, BUS_BASE | OFF_NR52, 8'h00);
		send_fields(OP_WRITE, 8'd0, BUS_BASE | OFF_NR52, 8'h00);
		send_fields(OP_READ, 8'd0, BUS_BASE | OFF_WAVE_HI, 8'h00);
		send_fields(OP_READ, 8'd0, BUS_BASE | OFF_NR52, 8'h00);
		send_fields(OP_ADVANCE, 8'd1, 16'h0000, 8'h00);
		send_fields(OP_WRITE, 8'd0, BUS_BASE | OFF_NR52, 8'hFF);
		send_fields(OP_READ, 8'd0, BUS_BASE | OFF_NR50, 8'h00);

		for (ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				foreach (next_gain[i])
					case (ph)
						1: next_gain[i] = 10'd1023;
						2: next_gain[i] = 10'd0;
						3: next_gain[i] = (i == CFG_MASTER) ? 10'd1023 : gain_t'($urandom);
						4: next_gain[i] = gain_t'($urandom);
						default: next_gain[i] = (i == CFG_MASTER) ? gain_t'($urandom) : GAIN_RESET;
					endcase
				write_gains();
			end
			case (ph)
				1: begin src_idle_pct = 62; sink_stall_pct = 0; end
				2: begin src_idle_pct = 0; sink_stall_pct = 62; end
				3, 5: begin src_idle_pct = 34; sink_stall_pct = 34; end
				default: begin src_idle_pct = 0; sink_stall_pct = 0; end
			endcase
			if (ph == 4) hold_left = 400;
			if (ph == PHASES - 1) run_random(400, 75, 1'b1);
			else run_random(290, 55, 1'b0);
		end

		drain();
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// File: filelist.f
rtl/afsm_pkg.sv
rtl/afsm_lane.sv
rtl/afsm_merge.sv
rtl/afsm_timer.sv
rtl/afsm_regfile.sv
rtl/apu_frame_sequencer_mixer.sv
tb/tb_top.sv
